// ----- sv/tem_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the threshold edge map block.
// Used by tem_line_ram and threshold_edge_map; depends on nothing.
package tem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_BITS = 8;
   localparam int DIM_BITS = 11;
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   // Comparison width that holds a dimension register, a clamp bound and a counter.
   localparam int CMP_BITS = ((DIM_BITS > $clog2(MAX_WIDTH + 1)) ? DIM_BITS :
                             (($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                              $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1))) + 1;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT    = 2'd2;

   localparam logic [PIX_BITS-1:0] THRESHOLD_RESET = 8'd70;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET    = 11'd480;
   localparam logic [PIX_BITS-1:0] EDGE_ON         = 8'd255;
   localparam logic [PIX_BITS-1:0] EDGE_OFF        = 8'd0;

   // One read-modify-write access of the line store.
   typedef struct packed {
      logic                enable;
      logic [COL_BITS-1:0] addr;
      logic                wbit;
   } ram_req_type;

endpackage

// ----- sv/tem_line_ram.sv -----
`timescale 1ns / 1ps
// One-bit line store holding the binary values of the previous row.
// Depends on tem_pkg; read-first, registered read data, one access per cycle.
module tem_line_ram
   import tem_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic        rd_bit
);

   logic mem [MAX_WIDTH];
   logic rd_bit_ff;

   // The old value comes out while the new one goes in, so the pixel above
   // is fetched and replaced by the current pixel in the same access.
   always_ff @(posedge clock) begin
      if (ram_req.enable) begin
         rd_bit_ff <= mem[ram_req.addr];
         mem[ram_req.addr] <= ram_req.wbit;
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

// ----- sv/threshold_edge_map.sv -----
`timescale 1ns / 1ps
// Top level of the binary threshold edge map over a raster pixel stream.
// Depends on tem_pkg and tem_line_ram.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_grey_pixel
//   rsp_      out        rsp_valid / rsp_stall  rsp_edge_pixel, rsp_end_of_row,
//                                               rsp_end_of_frame
//   csr_      in         csr_write_enable       csr_index, csr_write_data
//
// One item per cycle sustained while the output is not stalled. An accepted item
// is registered in the s1 stage, alongside the registered read of the line store,
// and then in the output register, from which its result can leave.
// Reset clears the counters, the left bit, the pipeline valids and restores the
// registers; the line store is not cleared and needs no clearing pass.
// A stalled output holds the whole pipeline; req_stall rises in the same cycle.
module threshold_edge_map
   import tem_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIX_BITS-1:0]     req_grey_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIX_BITS-1:0]     rsp_edge_pixel,
   output logic                    rsp_end_of_row,
   output logic                    rsp_end_of_frame,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]     csr_write_data
);

   logic [PIX_BITS-1:0] threshold_ff;
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                left_ff;

   logic s1_valid_ff, s1_bit_ff, s1_left_ff, s1_col_nz_ff, s1_row_nz_ff;
   logic s1_eor_ff, s1_eof_ff;

   logic                rsp_valid_ff;
   logic [PIX_BITS-1:0] rsp_edge_ff;
   logic                rsp_eor_ff, rsp_eof_ff;

   logic                advance, accept, pix_bit, last_col, last_row, edge_hit, rd_above;
   logic [CMP_BITS-1:0] w_use, h_use;
   ram_req_type         ram_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_write_data[PIX_BITS-1:0];
            CSR_WIDTH:     width_ff     <= csr_write_data;
            CSR_HEIGHT:    height_ff    <= csr_write_data;
            default:       ;
         endcase
      end
   end

   // Geometry in use is the register value held to the supported range.
   always_comb begin
      w_use = CMP_BITS'(width_ff);
      if (w_use < CMP_BITS'(2)) w_use = CMP_BITS'(2);
      else if (w_use > CMP_BITS'(MAX_WIDTH)) w_use = CMP_BITS'(MAX_WIDTH);
      h_use = CMP_BITS'(height_ff);
      if (h_use < CMP_BITS'(2)) h_use = CMP_BITS'(2);
      else if (h_use > CMP_BITS'(MAX_HEIGHT)) h_use = CMP_BITS'(MAX_HEIGHT);
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign pix_bit   = (req_grey_pixel < threshold_ff);
   assign last_col  = (CMP_BITS'(col_ff) >= w_use - CMP_BITS'(1));
   assign last_row  = (CMP_BITS'(row_ff) >= h_use - CMP_BITS'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_comb begin
      ram_req.enable = accept;
      ram_req.addr   = col_ff;
      ram_req.wbit   = pix_bit;
   end

   tem_line_ram u_line_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_bit  (rd_above)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) left_ff <= pix_bit;
         if (advance) begin
            s1_valid_ff  <= accept;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bit_ff    <= pix_bit;
         s1_left_ff   <= left_ff;
         s1_col_nz_ff <= (col_ff != '0);
         s1_row_nz_ff <= (row_ff != '0);
         s1_eor_ff    <= last_col;
         s1_eof_ff    <= last_col && last_row;
      end
   end

   assign edge_hit = (s1_row_nz_ff && (rd_above != s1_bit_ff)) ||
                     (s1_col_nz_ff && (s1_left_ff != s1_bit_ff));

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_edge_ff <= edge_hit ? EDGE_ON : EDGE_OFF;
         rsp_eor_ff  <= s1_eor_ff;
         rsp_eof_ff  <= s1_eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_edge_pixel   = rsp_edge_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   a_eof_on_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_eof_ff || rsp_eor_ff))
      else $error("end of frame without end of row");

   a_edge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_edge_ff == EDGE_ON || rsp_edge_ff == EDGE_OFF))
      else $error("edge pixel is neither on nor off");

   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col |=> col_ff == '0)
      else $error("column counter did not wrap at end of row");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      accept && !last_col |=> col_ff == $past(col_ff) + COL_BITS'(1))
      else $error("column counter did not advance");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && s1_valid_ff |=> s1_valid_ff)
      else $error("item in flight lost under stall");

endmodule
